### design/assert_macros.svh
// Assertion macros shared by the reverb core modules.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high
`define CARA_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define CARA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/cara_pkg.sv
// Package for the comb/allpass reverb core: widths, register codes,
// delay tunings, sequencer states and shared helper functions. No dependencies.
`timescale 1ns / 1ps
package cara_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 16;
  localparam int GAIN_FRAC   = COEF_W - 2;
  localparam int POS_C_W     = 11;
  localparam int POS_A_W     = 10;
  localparam int CFG_IDX_W   = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROOM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRY  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET  = 8'd3;

  localparam logic [COEF_W-1:0] ROOM_RESET = 16'd55050;
  localparam logic [COEF_W-1:0] DAMP_RESET = 16'd13107;
  localparam logic [COEF_W-1:0] DRY_RESET  = 16'd22938;
  localparam logic [COEF_W-1:0] WET_RESET  = 16'd14746;

  typedef struct packed {
    logic [COEF_W-1:0] room;
    logic [COEF_W-1:0] damp;
    logic [COEF_W-1:0] dry;
    logic [COEF_W-1:0] wet;
  } cfg_t;

  // Queue head as seen by the engine
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
  } q_head_t;

  typedef struct packed {
    logic clearing;
  } eng_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_C_ADDR,
    S_C_WAIT,
    S_C_MUL1,
    S_C_MUL2,
    S_C_LP,
    S_C_FB,
    S_C_WR,
    S_A_ADDR,
    S_A_WAIT,
    S_A_UPD,
    S_M_DRY,
    S_M_WET,
    S_M_OUT
  } eng_state_t;

  function automatic logic [POS_C_W-1:0] comb_tune(input logic [3:0] k);
    logic [POS_C_W-1:0] t;
    case (k)
      4'd0:    t = 11'd1116;
      4'd1:    t = 11'd1188;
      4'd2:    t = 11'd1277;
      4'd3:    t = 11'd1356;
      4'd4:    t = 11'd1422;
      4'd5:    t = 11'd1491;
      4'd6:    t = 11'd1557;
      4'd7:    t = 11'd1617;
      4'd8:    t = 11'd1139;
      4'd9:    t = 11'd1211;
      4'd10:   t = 11'd1300;
      4'd11:   t = 11'd1379;
      4'd12:   t = 11'd1445;
      4'd13:   t = 11'd1514;
      4'd14:   t = 11'd1580;
      default: t = 11'd1640;
    endcase
    return t;
  endfunction

  function automatic logic [POS_A_W-1:0] ap_tune(input logic [2:0] k);
    logic [POS_A_W-1:0] t;
    case (k)
      3'd0:    t = 10'd556;
      3'd1:    t = 10'd441;
      3'd2:    t = 10'd341;
      3'd3:    t = 10'd225;
      3'd4:    t = 10'd579;
      3'd5:    t = 10'd464;
      3'd6:    t = 10'd364;
      default: t = 10'd248;
    endcase
    return t;
  endfunction

  // Clamp to the signed sample range
  function automatic logic signed [SAMPLE_W-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[SAMPLE_W-1:0];
    if (v < lo) return lo[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

  // Round half up, then floor by 2^s
  function automatic logic signed [63:0] rshift(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

endpackage

### design/cara_in_if.sv
// Input sample channel: valid/ready with one signed sample.
// Depends on cara_pkg for the sample width.
`timescale 1ns / 1ps
interface cara_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cara_pkg::SAMPLE_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

### design/cara_out_if.sv
// Output sample channel: valid/ready with one signed sample.
// Depends on cara_pkg for the sample width.
`timescale 1ns / 1ps
interface cara_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cara_pkg::SAMPLE_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### design/cara_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on cara_pkg for the widths.
`timescale 1ns / 1ps
interface cara_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cara_pkg::CFG_IDX_W-1:0]    wr_index;
  logic [cara_pkg::COEF_W-1:0]       wr_data;
  modport source (output valid, output wr_index, output wr_data, input ready);
  modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

### design/cara_front.sv
// Front end: accepts input samples into a short queue for the engine.
// Depends on cara_pkg, cara_in_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cara_front (
  input  logic                  clk,
  input  logic                  rst,
  cara_in_if.sink               in_ch,
  input  cara_pkg::eng_status_t status,
  output cara_pkg::q_head_t     head,
  input  logic                  head_ready
);

  logic signed [cara_pkg::SAMPLE_W-1:0] qbuf [cara_pkg::QUEUE_DEPTH];
  logic [cara_pkg::QPTR_W-1:0] wr_ptr;
  logic [cara_pkg::QPTR_W-1:0] rd_ptr;
  logic [cara_pkg::QCNT_W-1:0] count;
  logic push;
  logic pop;

  // Hold off new transactions while full or while the stores are cleared
  assign in_ch.ready = (count != cara_pkg::QCNT_W'(cara_pkg::QUEUE_DEPTH)) && !status.clearing;
  assign push = in_ch.valid && in_ch.ready;
  assign head.valid = (count != '0);
  assign head.sample = qbuf[rd_ptr];
  assign pop = head.valid && head_ready;

  // Store pushed samples
  always_ff @(posedge clk) begin
    if (push) begin
      qbuf[wr_ptr] <= in_ch.sample_in;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CARA_ASSERT(a_count_bound, clk, rst, (count <= cara_pkg::QCNT_W'(cara_pkg::QUEUE_DEPTH)), "queue count over depth")
  `CARA_ASSERT(a_no_push_full, clk, rst, (count == cara_pkg::QCNT_W'(cara_pkg::QUEUE_DEPTH)) |-> !push, "push into full queue")
  `CARA_ASSERT(a_no_push_clear, clk, rst, status.clearing |-> !push, "push during clearing pass")

endmodule

### design/cara_engine.sv
// Back end: sequences comb and allpass lines through one shared multiplier, owns the
// delay memories and output register. Uses cara_pkg, cara_out_if, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cara_engine #(
  parameter int NUM_COMBS           = 8,
  parameter int NUM_ALLPASSES       = 4,
  parameter int COMB_STORE_DEPTH    = 11024,
  parameter int ALLPASS_STORE_DEPTH = 1563
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cara_pkg::cfg_t        cfg,
  input  cara_pkg::q_head_t     head,
  output logic                  head_ready,
  output cara_pkg::eng_status_t status,
  cara_out_if.source            out_ch
);

  localparam int SW    = cara_pkg::SAMPLE_W;
  localparam int CW    = cara_pkg::COEF_W;
  localparam int CIW   = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
  localparam int AIW   = (NUM_ALLPASSES > 1) ? $clog2(NUM_ALLPASSES) : 1;
  localparam int SUM_W = SW + CIW + 1 + NUM_ALLPASSES;
  localparam int MB_W  = CW + 2;
  localparam int PR_W  = SUM_W + MB_W;
  localparam int ACC_W = PR_W + 1;
  localparam int CAW   = $clog2(COMB_STORE_DEPTH);
  localparam int AAW   = $clog2(ALLPASS_STORE_DEPTH);
  localparam int CBW   = $clog2(COMB_STORE_DEPTH + 1);
  localparam int ABW   = $clog2(ALLPASS_STORE_DEPTH + 1);
  localparam int CLR_N = (COMB_STORE_DEPTH > ALLPASS_STORE_DEPTH) ?
                         COMB_STORE_DEPTH : ALLPASS_STORE_DEPTH;
  localparam int CLR_W = $clog2(CLR_N);

  cara_pkg::eng_state_t state, state_next;

  logic signed [SW-1:0] comb_mem [COMB_STORE_DEPTH];
  logic signed [SW-1:0] ap_mem [ALLPASS_STORE_DEPTH];
  logic signed [SW-1:0] cm_rdata;
  logic signed [SW-1:0] am_rdata;
  logic                 cm_we, am_we;
  logic [CAW-1:0]       cm_waddr;
  logic [AAW-1:0]       am_waddr;
  logic signed [SW-1:0] cm_wdata, am_wdata;

  logic [cara_pkg::POS_C_W-1:0] cpos [2**CIW];
  logic signed [SW-1:0]         clp [2**CIW];
  logic [cara_pkg::POS_A_W-1:0] apos [2**AIW];

  logic [CLR_W-1:0]  clr;
  logic [CIW-1:0]    kc;
  logic [AIW-1:0]    ka;
  logic [CBW-1:0]    base_c;
  logic [ABW-1:0]    base_a;
  logic [CAW-1:0]    addr_c;
  logic [AAW-1:0]    addr_a;
  logic [cara_pkg::POS_C_W-1:0] pos_c, len_c;
  logic [cara_pkg::POS_A_W-1:0] pos_a, len_a;
  logic signed [SW-1:0]    x;
  logic signed [SUM_W-1:0] sum;
  logic signed [ACC_W-1:0] acc;
  logic signed [SW-1:0]    lp_q;
  logic                    out_valid;
  logic signed [SW-1:0]    out_data;

  logic [cara_pkg::POS_C_W-1:0] tune_c, clen, cpos_rd, cpos_use, cpos_nxt;
  logic [cara_pkg::POS_A_W-1:0] tune_a, alen, apos_rd, apos_use, apos_nxt;
  logic [CBW-1:0]          crem;
  logic [ABW-1:0]          arem;
  logic signed [SUM_W-1:0] mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PR_W-1:0]  prod;
  logic [CW:0]             d2;
  logic signed [SW-1:0]    lp_new, fb_word, ap_word, mix_word;
  logic                    out_free;
  logic                    last_c, last_a;

  assign status.clearing = (state == cara_pkg::S_CLEAR);
  assign out_ch.valid = out_valid;
  assign out_ch.sample_out = out_data;
  assign out_free = !out_valid || out_ch.ready;
  assign last_c = (kc == CIW'(NUM_COMBS - 1));
  assign last_a = (ka == AIW'(NUM_ALLPASSES - 1));

  // Line length: tuning, cut to what remains of the store
  always_comb begin
    tune_c = cara_pkg::comb_tune(4'(kc));
    crem = CBW'(COMB_STORE_DEPTH) - base_c;
    if (base_c >= CBW'(COMB_STORE_DEPTH)) clen = '0;
    else if (CBW'(tune_c) > crem) clen = cara_pkg::POS_C_W'(crem);
    else clen = tune_c;
    cpos_rd = cpos[kc];
    cpos_use = (cpos_rd >= clen) ? '0 : cpos_rd;
    cpos_nxt = (pos_c + 1'b1 >= len_c) ? '0 : pos_c + 1'b1;

    tune_a = cara_pkg::ap_tune(3'(ka));
    arem = ABW'(ALLPASS_STORE_DEPTH) - base_a;
    if (base_a >= ABW'(ALLPASS_STORE_DEPTH)) alen = '0;
    else if (ABW'(tune_a) > arem) alen = cara_pkg::POS_A_W'(arem);
    else alen = tune_a;
    apos_rd = apos[ka];
    apos_use = (apos_rd >= alen) ? '0 : apos_rd;
    apos_nxt = (pos_a + 1'b1 >= len_a) ? '0 : pos_a + 1'b1;
  end

  // Shared multiplier operand select
  always_comb begin
    d2 = {1'b1, {CW{1'b0}}} - {1'b0, cfg.damp};
    case (state)
      cara_pkg::S_C_MUL1: begin
        mul_a = SUM_W'(cm_rdata);
        mul_b = MB_W'({1'b0, d2});
      end
      cara_pkg::S_C_MUL2: begin
        mul_a = SUM_W'(clp[kc]);
        mul_b = MB_W'({2'b00, cfg.damp});
      end
      cara_pkg::S_C_FB: begin
        mul_a = SUM_W'(lp_q);
        mul_b = MB_W'({2'b00, cfg.room});
      end
      cara_pkg::S_M_DRY: begin
        mul_a = SUM_W'(x);
        mul_b = MB_W'({2'b00, cfg.dry});
      end
      default: begin
        mul_a = sum;
        mul_b = MB_W'({2'b00, cfg.wet});
      end
    endcase
    prod = mul_a * mul_b;
  end

  // Rounded and clamped words
  always_comb begin
    lp_new   = cara_pkg::sat(cara_pkg::rshift(64'(acc), CW));
    fb_word  = cara_pkg::sat(64'(x) + cara_pkg::rshift(64'(acc), CW));
    ap_word  = cara_pkg::sat(64'(am_rdata) - 64'(sum));
    mix_word = cara_pkg::sat(cara_pkg::rshift(64'(acc), cara_pkg::GAIN_FRAC));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cara_pkg::S_CLEAR:  if (clr == CLR_W'(CLR_N - 1)) state_next = cara_pkg::S_IDLE;
      cara_pkg::S_IDLE:   if (head.valid) state_next = cara_pkg::S_C_ADDR;
      cara_pkg::S_C_ADDR: state_next = (clen == '0) ? cara_pkg::S_A_ADDR : cara_pkg::S_C_WAIT;
      cara_pkg::S_C_WAIT: state_next = cara_pkg::S_C_MUL1;
      cara_pkg::S_C_MUL1: state_next = cara_pkg::S_C_MUL2;
      cara_pkg::S_C_MUL2: state_next = cara_pkg::S_C_LP;
      cara_pkg::S_C_LP:   state_next = cara_pkg::S_C_FB;
      cara_pkg::S_C_FB:   state_next = cara_pkg::S_C_WR;
      cara_pkg::S_C_WR:   state_next = last_c ? cara_pkg::S_A_ADDR : cara_pkg::S_C_ADDR;
      cara_pkg::S_A_ADDR: state_next = (alen == '0) ? cara_pkg::S_M_DRY : cara_pkg::S_A_WAIT;
      cara_pkg::S_A_WAIT: state_next = cara_pkg::S_A_UPD;
      cara_pkg::S_A_UPD:  state_next = last_a ? cara_pkg::S_M_DRY : cara_pkg::S_A_ADDR;
      cara_pkg::S_M_DRY:  state_next = cara_pkg::S_M_WET;
      cara_pkg::S_M_WET:  state_next = cara_pkg::S_M_OUT;
      cara_pkg::S_M_OUT:  if (out_free) state_next = cara_pkg::S_IDLE;
      default:            state_next = cara_pkg::S_CLEAR;
    endcase
  end

  // Memory strobes and queue pop
  always_comb begin
    head_ready = 1'b0;
    cm_we = 1'b0;
    am_we = 1'b0;
    cm_waddr = addr_c;
    am_waddr = addr_a;
    cm_wdata = fb_word;
    am_wdata = ap_word;
    case (state)
      cara_pkg::S_CLEAR: begin
        cm_we = ({1'b0, clr} < (CLR_W + 1)'(COMB_STORE_DEPTH));
        am_we = ({1'b0, clr} < (CLR_W + 1)'(ALLPASS_STORE_DEPTH));
        cm_waddr = CAW'(clr);
        am_waddr = AAW'(clr);
        cm_wdata = '0;
        am_wdata = '0;
      end
      cara_pkg::S_IDLE:  head_ready = 1'b1;
      cara_pkg::S_C_WR:  cm_we = 1'b1;
      cara_pkg::S_A_UPD: am_we = 1'b1;
      default: ;
    endcase
  end

  // Delay memories, registered read
  always_ff @(posedge clk) begin
    if (cm_we) comb_mem[cm_waddr] <= cm_wdata;
    cm_rdata <= comb_mem[addr_c];
  end

  always_ff @(posedge clk) begin
    if (am_we) ap_mem[am_waddr] <= am_wdata;
    am_rdata <= ap_mem[addr_a];
  end

  // Control and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cara_pkg::S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 2**CIW; i++) begin
        cpos[i] <= '0;
        clp[i] <= '0;
      end
      for (int i = 0; i < 2**AIW; i++) apos[i] <= '0;
    end else begin
      state <= state_next;
      // Raise the result when the mix lands, drop it once taken
      if (state == cara_pkg::S_M_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        cara_pkg::S_CLEAR: clr <= clr + 1'b1;
        cara_pkg::S_C_LP:  clp[kc] <= lp_new;
        cara_pkg::S_C_WR:  cpos[kc] <= cpos_nxt;
        cara_pkg::S_A_UPD: apos[ka] <= apos_nxt;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      cara_pkg::S_IDLE: begin
        x <= head.sample;
        sum <= '0;
        kc <= '0;
        base_c <= '0;
      end
      cara_pkg::S_C_ADDR: begin
        pos_c <= cpos_use;
        len_c <= clen;
        addr_c <= CAW'(base_c + CBW'(cpos_use));
        ka <= '0;
        base_a <= '0;
      end
      cara_pkg::S_C_MUL1: begin
        acc <= ACC_W'(prod);
        sum <= sum + SUM_W'(cm_rdata);
      end
      cara_pkg::S_C_MUL2: acc <= acc + ACC_W'(prod);
      cara_pkg::S_C_LP:   lp_q <= lp_new;
      cara_pkg::S_C_FB:   acc <= ACC_W'(prod);
      cara_pkg::S_C_WR: begin
        base_c <= base_c + CBW'(len_c);
        kc <= kc + 1'b1;
        ka <= '0;
        base_a <= '0;
      end
      cara_pkg::S_A_ADDR: begin
        pos_a <= apos_use;
        len_a <= alen;
        addr_a <= AAW'(base_a + ABW'(apos_use));
      end
      cara_pkg::S_A_UPD: begin
        sum <= sum + SUM_W'(am_rdata);
        base_a <= base_a + ABW'(len_a);
        ka <= ka + 1'b1;
      end
      cara_pkg::S_M_DRY: acc <= ACC_W'(prod);
      cara_pkg::S_M_WET: acc <= acc + ACC_W'(prod);
      cara_pkg::S_M_OUT: if (out_free) out_data <= mix_word;
      default: ;
    endcase
  end

  `CARA_ASSERT(a_no_pop_clear, clk, rst, (state == cara_pkg::S_CLEAR) |-> !head_ready, "queue popped during clearing pass")
  `CARA_ASSERT(a_out_from_mix, clk, rst, $rose(out_valid) |-> ($past(state) == cara_pkg::S_M_OUT), "result raised outside mix step")
  `CARA_ASSERT(a_comb_pos_bound, clk, rst, (state == cara_pkg::S_C_WR) |-> (pos_c < len_c), "comb position past line end")
  `CARA_ASSERT(a_ap_pos_bound, clk, rst, (state == cara_pkg::S_A_UPD) |-> (pos_a < len_a), "allpass position past line end")

endmodule

### design/comb_allpass_reverb_core.sv
// Steps: each active comb line runs address, wait, two multiplies, low-pass,
// feedback and write; each allpass line runs address, wait and update; the mix
// runs dry, wet and output; an idle step takes each sample, only once the last
// result is registered. The output step stalls while the prior one is unread.
// Reset: synchronous; a clearing pass over max(comb, allpass store depth)
// addresses zeroes the stores; samples wait, config writes are taken.
`timescale 1ns / 1ps
module comb_allpass_reverb_core #(
  parameter int NUM_COMBS           = 8,
  parameter int NUM_ALLPASSES       = 4,
  parameter int COMB_STORE_DEPTH    = 11024,
  parameter int ALLPASS_STORE_DEPTH = 1563
) (
  input logic        clk,
  input logic        rst,
  cara_in_if.sink    in_ch,
  cara_out_if.source out_ch,
  cara_cfg_if.sink   cfg
);

  cara_pkg::cfg_t        cfg_regs;
  cara_pkg::q_head_t     head;
  cara_pkg::eng_status_t status;
  logic                  head_ready;

  assign cfg.ready = 1'b1;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.room <= cara_pkg::ROOM_RESET;
      cfg_regs.damp <= cara_pkg::DAMP_RESET;
      cfg_regs.dry  <= cara_pkg::DRY_RESET;
      cfg_regs.wet  <= cara_pkg::WET_RESET;
    end else if (cfg.valid) begin
      case (cfg.wr_index)
        cara_pkg::REG_ROOM: cfg_regs.room <= cfg.wr_data;
        cara_pkg::REG_DAMP: cfg_regs.damp <= cfg.wr_data;
        cara_pkg::REG_DRY:  cfg_regs.dry  <= cfg.wr_data;
        cara_pkg::REG_WET:  cfg_regs.wet  <= cfg.wr_data;
        default: ;
      endcase
    end
  end

  cara_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .status     (status),
    .head       (head),
    .head_ready (head_ready)
  );

  cara_engine #(
    .NUM_COMBS           (NUM_COMBS),
    .NUM_ALLPASSES       (NUM_ALLPASSES),
    .COMB_STORE_DEPTH    (COMB_STORE_DEPTH),
    .ALLPASS_STORE_DEPTH (ALLPASS_STORE_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .head       (head),
    .head_ready (head_ready),
    .status     (status),
    .out_ch     (out_ch)
  );

endmodule
